[hw/rtl/pdsc_pkg.sv]
// pdsc_pkg: widths, constants, register codes and shared types for the
// PD servo position controller. No dependencies.
package pdsc_pkg;

  // Field widths
  localparam int POS_W      = 16;
  localparam int TS_W       = 32;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 7;
  localparam int CMD_W      = 8;
  localparam int DRIVE_W    = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_GAIN     = 2'd0,
    REG_KD_GAIN     = 2'd1,
    REG_DRIVE_LIMIT = 2'd2
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0]  KP_RESET    = 16'd614;
  localparam logic [GAIN_W-1:0]  KD_RESET    = 16'd51;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd100;

  // Derivative path
  localparam int DE_W       = POS_W + 1;          // error difference
  localparam int DE_MAG_W   = POS_W;              // |de| <= 65535
  localparam int SCALE_W    = 20;
  localparam logic [SCALE_W-1:0] DERIV_SCALE = 20'd1000000;
  localparam int NUM_W      = DE_MAG_W + SCALE_W; // dividend magnitude
  localparam int DEN_W      = TS_W;               // elapsed microseconds
  localparam int DERIV_W    = 42;                 // holds +-2^40
  localparam logic [DERIV_W-1:0] DERIV_SAT = DERIV_W'(1) << 40;

  // Gain products and their sum
  localparam int ACC_W      = 60;

  // Drive clamp and servo mapping
  localparam logic [LIMIT_W-1:0] DRIVE_MAX = 7'd100;
  localparam logic [CMD_W-1:0]   CMD_MAX   = 8'd180;
  localparam logic [CMD_W-1:0]   STOP_CMD  = 8'd90;
  localparam logic [CMD_W-1:0]   PUSH_UP   = 8'd102;
  localparam logic [CMD_W-1:0]   PUSH_DOWN = 8'd80;
  localparam logic [CMD_W-1:0]   UP_LO     = STOP_CMD + 8'd1;
  localparam logic [CMD_W-1:0]   UP_HI     = PUSH_UP - 8'd1;
  localparam logic [CMD_W-1:0]   DN_LO     = PUSH_DOWN + 8'd1;
  localparam logic [CMD_W-1:0]   DN_HI     = STOP_CMD - 8'd1;

  // floor(x * 180 / 200) == (x * 58986) >> 16 for x in 0..200
  localparam int MAP_SHIFT  = 16;
  localparam int MAP_PROD_W = 24;
  localparam logic [15:0] MAP_RECIP = 16'd58986;

  // Command to the serial multiply-accumulate unit
  typedef struct packed {
    logic start;  // load operands and begin a run
    logic clear;  // zero the accumulator at start
  } mac_cmd_t;

endpackage

[hw/rtl/pdsc_if.sv]
// pdsc_if: valid/ready channel interfaces for the servo controller's
// sample input and result output. Depends on pdsc_pkg.
interface pdsc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pdsc_pkg::POS_W-1:0]   measured_position;
  logic signed [pdsc_pkg::POS_W-1:0]   target_position;
  logic                                reverse_direction;
  logic        [pdsc_pkg::TS_W-1:0]    timestamp_us;

  modport source (output valid, measured_position, target_position, reverse_direction,
                  timestamp_us, input ready);
  modport sink   (input valid, measured_position, target_position, reverse_direction,
                  timestamp_us, output ready);
  modport mon    (input valid, ready, measured_position, target_position,
                  reverse_direction, timestamp_us);
endinterface

interface pdsc_out_if;
  logic                                valid;
  logic                                ready;
  logic        [pdsc_pkg::CMD_W-1:0]   servo_command;
  logic signed [pdsc_pkg::DRIVE_W-1:0] drive_level;
  logic signed [pdsc_pkg::POS_W-1:0]   position_error;

  modport source (output valid, servo_command, drive_level, position_error, input ready);
  modport sink   (input valid, servo_command, drive_level, position_error, output ready);
  modport mon    (input valid, ready, servo_command, drive_level, position_error);
endinterface

[hw/rtl/pdsc_div.sv]
// pdsc_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on pdsc_pkg.
module pdsc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pdsc_pkg::NUM_W-1:0]    dividend,
  input  logic [pdsc_pkg::DEN_W-1:0]    divisor,
  output logic                          done,
  output logic [pdsc_pkg::NUM_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(pdsc_pkg::NUM_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(pdsc_pkg::NUM_W - 1);

  logic                       busy_r;
  logic                       done_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [pdsc_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [pdsc_pkg::DEN_W-1:0] den_r;
  logic [pdsc_pkg::NUM_W-1:0] nq_r;     // dividend bits out, quotient bits in
  logic [pdsc_pkg::DEN_W:0]   trial;
  logic [pdsc_pkg::DEN_W:0]   diff;
  logic                       fits;

  // one restoring step: bring down the next dividend bit, try to subtract
  always_comb begin
    trial   = {rem_r, nq_r[pdsc_pkg::NUM_W-1]};
    diff    = trial - {1'b0, den_r};
    fits    = ~diff[pdsc_pkg::DEN_W];
    rem_nxt = fits ? diff[pdsc_pkg::DEN_W-1:0] : trial[pdsc_pkg::DEN_W-1:0];
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= divisor;
      nq_r  <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      nq_r  <= {nq_r[pdsc_pkg::NUM_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = nq_r;

endmodule

[hw/rtl/pdsc_mac.sv]
// pdsc_mac: bit-serial multiply-accumulate, one gain bit per cycle.
// Signed multiplicand times unsigned gain, added to the accumulator. Depends on pdsc_pkg.
module pdsc_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pdsc_pkg::mac_cmd_t                cmd,
  input  logic signed [pdsc_pkg::ACC_W-1:0] mcand,
  input  logic        [pdsc_pkg::GAIN_W-1:0] mult,
  output logic                              done,
  output logic signed [pdsc_pkg::ACC_W-1:0] acc
);

  localparam int CNT_W = $clog2(pdsc_pkg::GAIN_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(pdsc_pkg::GAIN_W - 1);

  logic                               busy_r;
  logic                               done_r;
  logic [CNT_W-1:0]                   cnt_r;
  logic signed [pdsc_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [pdsc_pkg::ACC_W-1:0]  mcand_r;
  logic        [pdsc_pkg::GAIN_W-1:0] mult_r;

  // add the shifted multiplicand when the current gain bit is set
  assign acc_nxt = mult_r[0] ? acc_r + mcand_r : acc_r;

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand shift registers and accumulator
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      if (cmd.clear) begin
        acc_r <= '0;
      end
      mcand_r <= mcand;
      mult_r  <= mult;
    end else if (busy_r) begin
      acc_r   <= acc_nxt;
      mcand_r <= mcand_r <<< 1;
      mult_r  <= mult_r >> 1;
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

[hw/rtl/pd_servo_position_controller.sv]
// PD servo position controller, top level: sample front end, sequencer, clamp,
// servo mapping and output register. Uses pdsc_pkg, pdsc_if, pdsc_div, pdsc_mac.
// One sample at a time: input is ready only while the sequencer is idle. Each sample runs
//   through the 36-step serial divider (skipped when elapsed time is zero) and two 16-step
//   runs of the serial multiply-accumulate unit; a held result stalls the sequencer.
// Reset (synchronous, rst_n low): gains and limit to defaults, previous error
//   and last timestamp to zero, sequencer idle, no result pending.
module pd_servo_position_controller #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  pdsc_in_if.sink                             in_ch,
  pdsc_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [pdsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pdsc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int POS_W   = pdsc_pkg::POS_W;
  localparam int ACC_W   = pdsc_pkg::ACC_W;
  localparam int DERIV_W = pdsc_pkg::DERIV_W;
  localparam int DE_W    = pdsc_pkg::DE_W;
  localparam logic signed [ACC_W-1:0] FRAC_MASK =
    ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PREP = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_MACD = 9'b000010000,
    S_WKD  = 9'b000100000,
    S_WKP  = 9'b001000000,
    S_CLMP = 9'b010000000,
    S_MAP  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [pdsc_pkg::GAIN_W-1:0]  kp_r, kd_r;
  logic [pdsc_pkg::LIMIT_W-1:0] lim_r;

  // controller state
  logic signed [POS_W-1:0]          prev_err_r;
  logic        [pdsc_pkg::TS_W-1:0] last_ts_r;

  // captured sample
  logic signed [POS_W-1:0]          meas_r, tgt_r;
  logic                             rev_r;
  logic        [pdsc_pkg::TS_W-1:0] ts_r;

  // front end results
  logic signed [POS_W-1:0]              err_r;
  logic                                 de_neg_r;
  logic        [pdsc_pkg::DE_MAG_W-1:0] de_mag_r;
  logic        [pdsc_pkg::DEN_W-1:0]    el_r;

  logic signed [DERIV_W-1:0]            deriv_r;
  logic signed [ACC_W-1:0]              drive_r;
  logic signed [pdsc_pkg::DRIVE_W-1:0]  clamp_r;

  // output register
  logic                                 out_valid_r;
  logic        [pdsc_pkg::CMD_W-1:0]    out_cmd_r;
  logic signed [pdsc_pkg::DRIVE_W-1:0]  out_drive_r;
  logic signed [POS_W-1:0]              out_err_r;

  logic in_beat, out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= pdsc_pkg::KP_RESET;
      kd_r  <= pdsc_pkg::KD_RESET;
      lim_r <= pdsc_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (pdsc_pkg::cfg_reg_t'(cfg_index))
        pdsc_pkg::REG_KP_GAIN:     kp_r  <= cfg_wdata;
        pdsc_pkg::REG_KD_GAIN:     kd_r  <= cfg_wdata;
        pdsc_pkg::REG_DRIVE_LIMIT: lim_r <= cfg_wdata[pdsc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: direction, saturated error, error change, elapsed time
  logic signed [DE_W-1:0]               tgt_ext, tgt_adj;
  logic signed [DE_W:0]                 diff;
  logic signed [POS_W-1:0]              err_sat;
  logic signed [DE_W-1:0]               de;
  logic        [pdsc_pkg::DE_MAG_W-1:0] de_mag;
  logic        [pdsc_pkg::DEN_W-1:0]    elapsed;

  always_comb begin
    tgt_ext = {tgt_r[POS_W-1], tgt_r};
    tgt_adj = rev_r ? -tgt_ext : tgt_ext;
    diff    = {tgt_adj[DE_W-1], tgt_adj} - {{2{meas_r[POS_W-1]}}, meas_r};
    if (diff[DE_W] != diff[DE_W-1] || diff[DE_W-1] != diff[POS_W-1]) begin
      err_sat = diff[DE_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      err_sat = diff[POS_W-1:0];
    end
    de      = {err_sat[POS_W-1], err_sat} - {prev_err_r[POS_W-1], prev_err_r};
    de_mag  = de[DE_W-1] ? pdsc_pkg::DE_MAG_W'(-de) : de[pdsc_pkg::DE_MAG_W-1:0];
    elapsed = ts_r - last_ts_r;
  end

  // divider: |de| * 1e6 / elapsed
  logic                          div_start, div_done;
  logic [pdsc_pkg::NUM_W-1:0]    div_num, div_quo;
  logic                          el_zero;

  assign el_zero   = (el_r == '0);
  assign div_start = (state_r == S_MUL) && !el_zero;
  assign div_num   = pdsc_pkg::NUM_W'(de_mag_r) * pdsc_pkg::NUM_W'(pdsc_pkg::DERIV_SCALE);

  pdsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (el_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // signed derivative, from the quotient or saturated at zero elapsed time
  logic signed [DERIV_W-1:0] quo_ext, deriv_div, deriv_sat;

  always_comb begin
    quo_ext   = DERIV_W'(div_quo);
    deriv_div = de_neg_r ? -quo_ext : quo_ext;
    if (de_mag_r == '0) begin
      deriv_sat = '0;
    end else begin
      deriv_sat = de_neg_r ? -$signed(pdsc_pkg::DERIV_SAT) : $signed(pdsc_pkg::DERIV_SAT);
    end
  end

  // multiply-accumulate: kd * derivative, then + kp * error
  pdsc_pkg::mac_cmd_t          mac_cmd;
  logic signed [ACC_W-1:0]     mac_mcand, mac_acc;
  logic [pdsc_pkg::GAIN_W-1:0] mac_mult;
  logic                        mac_done;

  always_comb begin
    mac_cmd   = '0;
    mac_mcand = {{(ACC_W-DERIV_W){deriv_r[DERIV_W-1]}}, deriv_r};
    mac_mult  = kd_r;
    if (state_r == S_MACD) begin
      mac_cmd.start = 1'b1;
      mac_cmd.clear = 1'b1;
    end else if (state_r == S_WKD) begin
      mac_mcand     = {{(ACC_W-POS_W){err_r[POS_W-1]}}, err_r};
      mac_mult      = kp_r;
      mac_cmd.start = mac_done;
    end
  end

  pdsc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mac_cmd),
    .mcand (mac_mcand),
    .mult  (mac_mult),
    .done  (mac_done),
    .acc   (mac_acc)
  );

  // drop the gain fraction, rounding toward zero
  logic signed [ACC_W-1:0] trunc_sum, drive_nxt;

  always_comb begin
    trunc_sum = mac_acc + (mac_acc[ACC_W-1] ? FRAC_MASK : {ACC_W{1'b0}});
    drive_nxt = trunc_sum >>> GAIN_FRAC_BITS;
  end

  // clamp to +-min(limit, 100)
  logic [pdsc_pkg::LIMIT_W-1:0]        lim_eff;
  logic signed [ACC_W-1:0]             lim_pos, lim_neg;
  logic signed [pdsc_pkg::DRIVE_W-1:0] clamp_nxt;

  always_comb begin
    lim_eff = (lim_r > pdsc_pkg::DRIVE_MAX) ? pdsc_pkg::DRIVE_MAX : lim_r;
    lim_pos = $signed({{(ACC_W-pdsc_pkg::LIMIT_W){1'b0}}, lim_eff});
    lim_neg = -lim_pos;
    if (drive_r > lim_pos) begin
      clamp_nxt = pdsc_pkg::DRIVE_W'(lim_pos);
    end else if (drive_r < lim_neg) begin
      clamp_nxt = pdsc_pkg::DRIVE_W'(lim_neg);
    end else begin
      clamp_nxt = pdsc_pkg::DRIVE_W'(drive_r);
    end
  end

  // map drive to servo command, then push out of the deadband
  logic [pdsc_pkg::CMD_W-1:0]      map_idx, cmd_raw, cmd_nxt;
  logic [pdsc_pkg::MAP_PROD_W-1:0] map_prod;

  always_comb begin
    map_idx  = pdsc_pkg::CMD_W'(clamp_r) + pdsc_pkg::CMD_W'(pdsc_pkg::DRIVE_MAX);
    map_prod = pdsc_pkg::MAP_PROD_W'(map_idx) * pdsc_pkg::MAP_PROD_W'(pdsc_pkg::MAP_RECIP);
    cmd_raw  = map_prod[pdsc_pkg::MAP_SHIFT +: pdsc_pkg::CMD_W];
    cmd_nxt  = cmd_raw;
    if (err_r != '0) begin
      if (cmd_raw inside {[pdsc_pkg::UP_LO:pdsc_pkg::UP_HI]}) begin
        cmd_nxt = pdsc_pkg::PUSH_UP;
      end else if (cmd_raw inside {[pdsc_pkg::DN_LO:pdsc_pkg::DN_HI]}) begin
        cmd_nxt = pdsc_pkg::PUSH_DOWN;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_beat) state_nxt = S_PREP;
      S_PREP: state_nxt = S_MUL;
      S_MUL:  state_nxt = el_zero ? S_MACD : S_DIV;
      S_DIV:  if (div_done) state_nxt = S_MACD;
      S_MACD: state_nxt = S_WKD;
      S_WKD:  if (mac_done) state_nxt = S_WKP;
      S_WKP:  if (mac_done) state_nxt = S_CLMP;
      S_CLMP: state_nxt = S_MAP;
      S_MAP:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_err_r  <= '0;
      last_ts_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_PREP) begin
        prev_err_r <= err_sat;
        last_ts_r  <= ts_r;
      end
      if (state_r == S_MAP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      meas_r <= in_ch.measured_position;
      tgt_r  <= in_ch.target_position;
      rev_r  <= in_ch.reverse_direction;
      ts_r   <= in_ch.timestamp_us;
    end
    if (state_r == S_PREP) begin
      err_r    <= err_sat;
      de_neg_r <= de[DE_W-1];
      de_mag_r <= de_mag;
      el_r     <= elapsed;
    end
    if (state_r == S_MUL && el_zero) begin
      deriv_r <= deriv_sat;
    end else if (state_r == S_DIV && div_done) begin
      deriv_r <= deriv_div;
    end
    if (state_r == S_WKP && mac_done) begin
      drive_r <= drive_nxt;
    end
    if (state_r == S_CLMP) begin
      clamp_r <= clamp_nxt;
    end
    if (state_r == S_MAP && out_free) begin
      out_cmd_r   <= cmd_nxt;
      out_drive_r <= clamp_r;
      out_err_r   <= err_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.servo_command  = out_cmd_r;
  assign out_ch.drive_level    = out_drive_r;
  assign out_ch.position_error = out_err_r;

endmodule

[hw/rtl/pdsc_chk.sv]
// pdsc_chk: port-level assertions for the PD servo position controller,
// bound to the top level. Depends on pdsc_pkg.
module pdsc_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic        [pdsc_pkg::CMD_W-1:0]   out_servo_command,
  input logic signed [pdsc_pkg::DRIVE_W-1:0] out_drive_level,
  input logic signed [pdsc_pkg::POS_W-1:0]   out_position_error
);

  // no result pending right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one sample at a time: ready drops after each input beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a sample is in work");

  // command and drive stay in range
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_servo_command <= pdsc_pkg::CMD_MAX) &&
                  (out_drive_level >= -8'sd100) && (out_drive_level <= 8'sd100))
    else $error("result out of range");

  // nonzero error never leaves the command inside the deadband
  a_deadband: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_position_error != 16'sd0) |->
      !((out_servo_command >= pdsc_pkg::UP_LO && out_servo_command <= pdsc_pkg::UP_HI) ||
        (out_servo_command >= pdsc_pkg::DN_LO && out_servo_command <= pdsc_pkg::DN_HI)))
    else $error("command left in deadband");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      out_valid && $stable(out_servo_command) && $stable(out_drive_level) &&
      $stable(out_position_error))
    else $error("stalled result beat changed");

endmodule

bind pd_servo_position_controller pdsc_chk u_pdsc_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_servo_command  (out_ch.servo_command),
  .out_drive_level    (out_ch.drive_level),
  .out_position_error (out_ch.position_error)
);

[bench/pd_servo_position_controller_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for pd_servo_position_controller: directed and random samples,
// an in-bench PD predictor and a scoreboard of expected servo results.
// Depends on pdsc_pkg, pdsc_if and the controller RTL.
module pd_servo_position_controller_tb;

  // shared widths, constants and register codes
  localparam int POS_W      = pdsc_pkg::POS_W;
  localparam int TS_W       = pdsc_pkg::TS_W;
  localparam int CMD_W      = pdsc_pkg::CMD_W;
  localparam int DRIVE_W    = pdsc_pkg::DRIVE_W;
  localparam int GAIN_W     = pdsc_pkg::GAIN_W;
  localparam int LIMIT_W    = pdsc_pkg::LIMIT_W;
  localparam int CFG_IDX_W  = pdsc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = pdsc_pkg::CFG_DATA_W;

  localparam logic [LIMIT_W-1:0]   DRIVE_MAX       = pdsc_pkg::DRIVE_MAX;
  localparam logic [CMD_W-1:0]     STOP_CMD        = pdsc_pkg::STOP_CMD;
  localparam logic [CMD_W-1:0]     PUSH_UP         = pdsc_pkg::PUSH_UP;
  localparam logic [CMD_W-1:0]     PUSH_DOWN       = pdsc_pkg::PUSH_DOWN;
  localparam logic [GAIN_W-1:0]    KP_RESET        = pdsc_pkg::KP_RESET;
  localparam logic [GAIN_W-1:0]    KD_RESET        = pdsc_pkg::KD_RESET;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET     = pdsc_pkg::LIMIT_RESET;
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN     = pdsc_pkg::REG_KP_GAIN;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN     = pdsc_pkg::REG_KD_GAIN;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = pdsc_pkg::REG_DRIVE_LIMIT;

  localparam int GAIN_FRAC_BITS  = 8;
  localparam int RESET_CYCLES    = 7;
  localparam int IDLE_PCT        = 22;
  localparam int MAX_GAP         = 90;
  localparam int HOLD_OFF_CYCLES = 500;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int END_WAIT        = 100;
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_ITEMS     = 64;

  localparam longint GAIN_DIV   = longint'(1) << GAIN_FRAC_BITS;
  localparam longint RATE_SAT   = longint'(1) << 40;
  localparam longint RATE_SCALE = 1000000;
  localparam longint MAP_IN     = 200;
  localparam longint MAP_OUT    = 180;
  localparam longint ERR_MAX    = 32767;
  localparam longint ERR_MIN    = -32768;

  // index with no register behind it; writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [POS_W-1:0] measured;
    logic signed [POS_W-1:0] target;
    logic                    reverse;
    logic [TS_W-1:0]         timestamp;
  } servo_sample_t;

  typedef struct packed {
    logic [CMD_W-1:0]          servo_command;
    logic signed [DRIVE_W-1:0] drive_level;
    logic signed [POS_W-1:0]   position_error;
  } servo_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pdsc_in_if  in_ch();
  pdsc_out_if out_ch();

  pd_servo_position_controller #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor copy of registers and loop state
  logic [GAIN_W-1:0]       kp_gain;
  logic [GAIN_W-1:0]       kd_gain;
  logic [LIMIT_W-1:0]      drive_limit;
  logic signed [POS_W-1:0] prev_error;
  logic [TS_W-1:0]         last_ts;

  servo_result_t expected_results[$];
  logic [TS_W-1:0] now_us;
  int  fail_count    = 0;
  int  samples_sent  = 0;
  int  results_seen  = 0;
  int  cfg_writes    = 0;
  int  stall_cycles  = 0;
  bit  steady_mode   = 1'b0;
  bit  hold_off_req  = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // PD step: error, rate, gain sum, clamp, servo mapping, deadband push
  function automatic servo_result_t compute_servo_result(servo_sample_t s);
    longint        tgt, err, de, rate, acc, drive, clamp, cmd;
    logic [TS_W-1:0] elapsed;
    servo_result_t r;
    tgt = longint'($signed(s.target));
    if (s.reverse) tgt = -tgt;
    err = tgt - longint'($signed(s.measured));
    if (err > ERR_MAX) err = ERR_MAX;
    else if (err < ERR_MIN) err = ERR_MIN;

    elapsed = s.timestamp - last_ts;
    de = err - longint'(prev_error);
    if (elapsed == '0) begin
      rate = (de > 0) ? RATE_SAT : ((de < 0) ? -RATE_SAT : 0);
    end else begin
      rate = (de * RATE_SCALE) / longint'({32'd0, elapsed});
    end

    acc   = longint'(kp_gain) * err + longint'(kd_gain) * rate;
    drive = acc / GAIN_DIV;
    clamp = (longint'(drive_limit) > longint'(DRIVE_MAX)) ? longint'(DRIVE_MAX)
                                                          : longint'(drive_limit);
    if (drive > clamp) drive = clamp;
    if (drive < -clamp) drive = -clamp;

    cmd = ((drive + longint'(DRIVE_MAX)) * MAP_OUT) / MAP_IN;
    if (err != 0) begin
      if (cmd > longint'(STOP_CMD) && cmd < longint'(PUSH_UP)) cmd = longint'(PUSH_UP);
      else if (cmd < longint'(STOP_CMD) && cmd > longint'(PUSH_DOWN)) cmd = longint'(PUSH_DOWN);
    end

    prev_error = POS_W'(err);
    last_ts    = s.timestamp;
    r.servo_command  = CMD_W'(cmd);
    r.drive_level    = DRIVE_W'(drive);
    r.position_error = POS_W'(err);
    return r;
  endfunction

  // one input beat; optional idle gap first, predictor runs at acceptance
  task automatic send_sample(input logic signed [POS_W-1:0] meas,
                             input logic signed [POS_W-1:0] tgt,
                             input logic rev, input logic [TS_W-1:0] ts);
    servo_sample_t s;
    if (!steady_mode && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.measured_position <= meas;
    in_ch.target_position   <= tgt;
    in_ch.reverse_direction <= rev;
    in_ch.timestamp_us      <= ts;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    s = '{meas, tgt, rev, ts};
    expected_results.push_back(compute_servo_result(s));
    samples_sent++;
  endtask

  // drop valid and wait until every result is back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // register write; only called with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_KP_GAIN:     kp_gain = value;
      REG_KD_GAIN:     kd_gain = value;
      REG_DRIVE_LIMIT: drive_limit = value[LIMIT_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] kd,
                           input logic [CFG_DATA_W-1:0] lim);
    drain_results();
    write_reg(REG_KP_GAIN, kp);
    write_reg(REG_KD_GAIN, kd);
    write_reg(REG_DRIVE_LIMIT, lim);
  endtask

  // random sample: mostly tracking near target, plus zero dt, noise and corners
  task automatic send_random_sample();
    int                      kind;
    logic signed [POS_W-1:0] tgt, meas;
    logic [TS_W-1:0]         ts;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      tgt    = POS_W'($urandom_range(0, 4000)) - 16'sd2000;
      meas   = tgt + (POS_W'($urandom_range(0, 200)) - 16'sd100);
      now_us = now_us + $urandom_range(1, 50000);
      ts     = now_us;
    end else if (kind < 70) begin
      tgt  = POS_W'($urandom_range(0, 400)) - 16'sd200;
      meas = POS_W'($urandom_range(0, 400)) - 16'sd200;
      ts   = now_us;
    end else if (kind < 85) begin
      tgt    = POS_W'($urandom);
      meas   = POS_W'($urandom);
      ts     = $urandom;
      now_us = ts;
    end else begin
      case ($urandom_range(0, 3))
        0: tgt = -16'sd32768;
        1: tgt = 16'sd32767;
        2: tgt = 16'sd0;
        default: tgt = -16'sd1;
      endcase
      case ($urandom_range(0, 3))
        0: meas = -16'sd32768;
        1: meas = 16'sd32767;
        2: meas = 16'sd0;
        default: meas = -16'sd1;
      endcase
      now_us = now_us + $urandom_range(1, 3);
      ts     = now_us;
    end
    send_sample(meas, tgt, 1'($urandom_range(0, 1)), ts);
  endtask

  // zero elapsed time right after reset: rate saturates in the sign of the change
  task automatic test_zero_elapsed();
    send_sample(16'sd0, 16'sd10, 1'b0, 32'd0);
    send_sample(16'sd0, 16'sd10, 1'b0, 32'd0);
    send_sample(16'sd20, 16'sd10, 1'b0, 32'd0);
  endtask

  // error saturation, including negation of the most negative target
  task automatic test_error_saturation();
    send_sample(-16'sd32768, 16'sd32767, 1'b0, 32'd1000);
    send_sample(16'sd32767, -16'sd32768, 1'b0, 32'd2000);
    send_sample(16'sd32767, -16'sd32768, 1'b1, 32'd3000);
    send_sample(-16'sd32768, -16'sd32768, 1'b1, 32'd4000);
    send_sample(16'sd0, 16'sd32767, 1'b1, 32'd5000);
  endtask

  // timestamp wrap and maximum timestamp
  task automatic test_timestamp_wrap();
    send_sample(16'sd5, 16'sd100, 1'b0, 32'hFFFF_FFF0);
    send_sample(16'sd5, 16'sd200, 1'b0, 32'h0000_0010);
    send_sample(16'sd5, 16'sd150, 1'b0, 32'hFFFF_FFFF);
    send_sample(16'sd5, 16'sd50, 1'b0, 32'hFFFF_FFFF);
  endtask

  // unity kp, no kd: drive equals error, walk across the deadband edges
  task automatic test_deadband();
    set_gains(16'd256, 16'd0, 16'd100);
    now_us = 32'd100;
    send_sample(16'sd0, 16'sd1, 1'b0, now_us);
    send_sample(16'sd0, 16'sd2, 1'b0, now_us + 32'd1000);
    send_sample(16'sd0, -16'sd1, 1'b0, now_us + 32'd2000);
    send_sample(16'sd0, -16'sd10, 1'b0, now_us + 32'd3000);
    send_sample(16'sd0, 16'sd12, 1'b0, now_us + 32'd4000);
    send_sample(16'sd0, 16'sd13, 1'b0, now_us + 32'd5000);
    send_sample(16'sd0, 16'sd14, 1'b0, now_us + 32'd6000);
    send_sample(16'sd12, 16'sd0, 1'b0, now_us + 32'd7000);
    send_sample(16'sd7, 16'sd7, 1'b0, now_us + 32'd8000);
    now_us = now_us + 32'd8000;
  endtask

  // zero limit, limit above 100 with junk upper bits, extreme gains
  task automatic test_limits_and_gains();
    set_gains(16'd614, 16'd51, 16'd0);
    send_sample(16'sd0, 16'sd50, 1'b0, now_us + 32'd500);
    set_gains(16'd614, 16'd51, 16'hFF7F);
    send_sample(16'sd0, 16'sd1000, 1'b0, now_us + 32'd1000);
    set_gains(16'hFFFF, 16'hFFFF, 16'd100);
    send_sample(16'sd300, -16'sd300, 1'b1, now_us + 32'd1500);
    set_gains(16'd0, 16'd0, 16'd100);
    send_sample(16'sd0, 16'sd400, 1'b0, now_us + 32'd2000);
    now_us = now_us + 32'd2000;
  endtask

  // receiver holds off while the sender keeps pushing, so the block backs up
  task automatic test_output_backpressure();
    set_gains(16'd614, 16'd51, 16'd100);
    steady_mode  = 1'b1;
    hold_off_req = 1'b1;
    repeat (12) send_random_sample();
    steady_mode = 1'b0;
    drain_results();
  endtask

  // random samples across several register settings, one phase without idling
  task automatic test_random_mix();
    logic [GAIN_W-1:0] kp, kd;
    logic [CFG_DATA_W-1:0] lim;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          kp  = 16'hFFFF;
          kd  = 16'hFFFF;
          lim = {9'($urandom_range(0, 511)), 7'h7F};
        end
        1: begin
          kp  = 16'd0;
          kd  = 16'd0;
          lim = 16'd0;
        end
        2: begin
          kp  = KP_RESET;
          kd  = KD_RESET;
          lim = 16'(LIMIT_RESET);
        end
        default: begin
          kp  = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 1024));
          kd  = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 256));
          lim = {9'($urandom_range(0, 511)), 7'($urandom_range(0, 127))};
        end
      endcase
      set_gains(kp, kd, lim);
      if (phase >= 3) write_reg(REG_UNUSED, 16'($urandom));
      steady_mode = (phase == 2);
      repeat (PHASE_ITEMS) send_random_sample();
      steady_mode = 1'b0;
    end
  endtask

  // result sink: random stalls, a counted hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        for (int n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (steady_mode) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // scoreboard: each result beat against the oldest expectation
  always @(posedge clk) begin
    servo_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result beat with no sample outstanding");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.servo_command !== want.servo_command) begin
          $error("servo_command: expected %0d, actual %0d",
                 want.servo_command, out_ch.servo_command);
          fail_count++;
        end
        if (out_ch.drive_level !== want.drive_level) begin
          $error("drive_level: expected %0d, actual %0d", want.drive_level, out_ch.drive_level);
          fail_count++;
        end
        if (out_ch.position_error !== want.position_error) begin
          $error("position_error: expected %0d, actual %0d",
                 want.position_error, out_ch.position_error);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat and no register write
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || cfg_we || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", stall_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n                   <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_index               <= REG_KP_GAIN;
    cfg_wdata               <= '0;
    in_ch.valid             <= 1'b0;
    in_ch.measured_position <= '0;
    in_ch.target_position   <= '0;
    in_ch.reverse_direction <= 1'b0;
    in_ch.timestamp_us      <= '0;
    kp_gain     = KP_RESET;
    kd_gain     = KD_RESET;
    drive_limit = LIMIT_RESET;
    prev_error  = '0;
    last_ts     = '0;
    now_us      = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_zero_elapsed();
    test_error_saturation();
    test_timestamp_wrap();
    test_deadband();
    test_limits_and_gains();
    test_output_backpressure();
    test_random_mix();

    drain_results();
    repeat (END_WAIT) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fail_count++;
    end
    $display("Run: %0d samples, %0d result beats, %0d register writes.",
             samples_sent, results_seen, cfg_writes);
    $display("Covered error saturation, zero dt, timestamp wrap, deadband, clamps, back-pressure.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
